>>> sv/rte_pkg.sv
// ============================================================================
// rte_pkg: shared types and constants of the retransmit timeout estimator
// Field widths, reset values, register indexes and the structs that pass
// between the input stage, the update datapath and the top level.
// ============================================================================
package rte_pkg;

  localparam int unsigned TickW   = 32;
  localparam int unsigned EstW    = 31;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 2;

  // Packed stream widths, padded up to whole bytes.
  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 96;

  localparam logic [CfgW-1:0] MinRtoReset     = 16'd200;
  localparam logic [CfgW-1:0] InitialRtoReset = 16'd200;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgMinRto     = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgInitialRto = 2'd1;

  typedef enum logic {
    CmdSample = 1'b0,
    CmdStop   = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [TickW-1:0] now_tick;
    logic [TickW-1:0] timer_expiry;
    logic             timer_armed;
    logic             backoff_pending;
  } item_t;

  typedef struct packed {
    logic [TickW-1:0] rto;
    logic [EstW-1:0]  srtt;
    logic [EstW-1:0]  rttvar;
  } est_t;

  typedef struct packed {
    logic sample_used;
    logic backoff_clear;
  } flags_t;

endpackage

>>> sv/rte_in_stage.sv
// ============================================================================
// rte_in_stage: input register of the estimator
// Holds one accepted word and releases it when the update stage advances.
// ============================================================================
module rte_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rte_pkg::item_t    in_item_i,
  input  logic              advance_i,
  output logic              item_valid_o,
  output rte_pkg::item_t    item_o
);

  logic           valid_q, valid_d;
  rte_pkg::item_t item_q;

  // The register may load whenever it is empty or its word moves on.
  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

>>> sv/rte_update.sv
// ============================================================================
// rte_update: estimate update datapath
// Computes the round trip sample, the smoothed averages and the new timeout
// for one word from the current estimates.
// ============================================================================
module rte_update (
  input  rte_pkg::item_t                 item_i,
  input  rte_pkg::est_t                  est_i,
  input  logic [rte_pkg::CfgW-1:0]       min_rto_i,
  input  logic [rte_pkg::CfgW-1:0]       initial_rto_i,
  output rte_pkg::est_t                  est_o,
  output rte_pkg::flags_t                flags_o
);

  logic [rte_pkg::TickW-1:0]   rtt_full;
  logic [rte_pkg::EstW-1:0]    rtt;
  logic [rte_pkg::EstW-1:0]    diff;
  logic [rte_pkg::EstW+2:0]    var_sum;
  logic [rte_pkg::EstW+2:0]    srtt_sum;
  logic [rte_pkg::EstW-1:0]    srtt_new;
  logic [rte_pkg::EstW-1:0]    var_new;
  logic [rte_pkg::EstW+1:0]    var_x4;
  logic [rte_pkg::EstW+1:0]    margin;
  logic [rte_pkg::EstW+2:0]    total;

  // Timer start is expiry minus the timeout; the sample is now minus start.
  assign rtt_full = item_i.now_tick - (item_i.timer_expiry - est_i.rto);
  assign rtt      = rtt_full[rte_pkg::EstW-1:0];

  assign diff = (est_i.srtt >= rtt) ? (est_i.srtt - rtt) : (rtt - est_i.srtt);

  // 3*rttvar + |srtt - rtt| and 7*srtt + rtt, floored by the shift below.
  assign var_sum  = ((rte_pkg::EstW+3)'(est_i.rttvar) << 1) +
                    (rte_pkg::EstW+3)'(est_i.rttvar) + (rte_pkg::EstW+3)'(diff);
  assign srtt_sum = ((rte_pkg::EstW+3)'(est_i.srtt) << 3) -
                    (rte_pkg::EstW+3)'(est_i.srtt) + (rte_pkg::EstW+3)'(rtt);

  always_comb begin
    if (est_i.srtt == '0) begin
      srtt_new = rtt;
      var_new  = {1'b0, rtt[rte_pkg::EstW-1:1]};
    end else begin
      srtt_new = srtt_sum[rte_pkg::EstW+2:3];
      var_new  = var_sum[rte_pkg::EstW+1:2];
    end
  end

  assign var_x4 = {var_new, 2'b00};
  assign margin = (var_x4 < (rte_pkg::EstW+2)'(min_rto_i)) ?
                  (rte_pkg::EstW+2)'(min_rto_i) : var_x4;
  assign total  = (rte_pkg::EstW+3)'(srtt_new) + (rte_pkg::EstW+3)'(margin);

  always_comb begin
    est_o   = est_i;
    flags_o = '0;
    priority if (item_i.cmd == rte_pkg::CmdStop) begin
      est_o.rto             = rte_pkg::TickW'(initial_rto_i);
      flags_o.backoff_clear = 1'b1;
    end else if (item_i.backoff_pending || !item_i.timer_armed) begin
      // Karn's rule: a retransmitted segment gives no measurement.
      flags_o.backoff_clear = 1'b1;
    end else if (!rtt_full[rte_pkg::TickW-1]) begin
      est_o.srtt          = srtt_new;
      est_o.rttvar        = var_new;
      est_o.rto           = (total[rte_pkg::EstW+2:rte_pkg::TickW] != '0) ?
                            '1 : total[rte_pkg::TickW-1:0];
      flags_o.sample_used = 1'b1;
    end else begin
      // A negative sample is dropped and the estimates stand.
      flags_o.sample_used = 1'b0;
    end
  end

endmodule

>>> sv/retransmit_timeout_estimator.sv
// ============================================================================
// retransmit_timeout_estimator: TCP retransmission timeout estimator
// Smooths round trip samples from acknowledgement words and keeps the timeout.
// ============================================================================
// Usage: each word on the slave stream is a command. With tuser low it is an
// acknowledgement sample carrying the current tick, the retransmit timer's
// expiry and two flags; with tuser high it stops the timer and reloads the
// timeout with initial_rto. Every word gives exactly one result word on the
// master stream with the new timeout, both estimates and two flags.
// The configuration channel writes min_rto (index 0) and initial_rto
// (index 1); other indexes are ignored. It is always ready and is meant to be
// used only while the block is idle.
// A result reaches the master side through the input register, which holds the
// accepted word, and the result register, which the update loads from it.
// One word is taken every cycle while the master side keeps up; the update of
// the three estimate registers completes in the same cycle that a word leaves
// the input register, so the following word already sees the new timeout.
// Reset clears both estimates, loads the timeout with 200 ticks and restores
// both configuration registers to 200. When the master side stalls, the
// result register holds its word; the input register can still take one more
// word, after which s_axis_tready drops until the result is taken.
// ============================================================================
module retransmit_timeout_estimator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Slave stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: now_tick[31:0], timer_expiry[63:32], timer_armed[64],
  //        backoff_pending[65], zero padding[71:66].
  input  logic [rte_pkg::InDataW-1:0]     s_axis_tdata,
  // tuser: cmd[0].
  input  logic                            s_axis_tuser,
  // Master stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata: rto_out[31:0], srtt_out[62:32], rttvar_out[93:63],
  //        sample_used[94], backoff_clear[95].
  output logic [rte_pkg::OutDataW-1:0]    m_axis_tdata,
  // Configuration write channel.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rte_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [rte_pkg::CfgW-1:0]        cfg_data_i
);

  rte_pkg::item_t   in_item;
  rte_pkg::item_t   item;
  logic             item_valid;
  logic             advance;
  rte_pkg::est_t    est_q, est_d;
  rte_pkg::flags_t  flags;
  logic [rte_pkg::CfgW-1:0] min_rto_q, initial_rto_q;
  logic             out_valid_q;
  rte_pkg::est_t    out_est_q;
  rte_pkg::flags_t  out_flags_q;

  assign in_item.cmd             = rte_pkg::cmd_e'(s_axis_tuser);
  assign in_item.now_tick        = s_axis_tdata[31:0];
  assign in_item.timer_expiry    = s_axis_tdata[63:32];
  assign in_item.timer_armed     = s_axis_tdata[64];
  assign in_item.backoff_pending = s_axis_tdata[65];

  // A word moves into the result register when that register is free or
  // its word is being taken in this cycle.
  assign advance = item_valid && (!out_valid_q || m_axis_tready);

  rte_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (in_item),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  rte_update u_update (
    .item_i        (item),
    .est_i         (est_q),
    .min_rto_i     (min_rto_q),
    .initial_rto_i (initial_rto_q),
    .est_o         (est_d),
    .flags_o       (flags)
  );

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_rto_q     <= rte_pkg::MinRtoReset;
      initial_rto_q <= rte_pkg::InitialRtoReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == rte_pkg::CfgMinRto) begin
        min_rto_q <= cfg_data_i;
      end else if (cfg_index_i == rte_pkg::CfgInitialRto) begin
        initial_rto_q <= cfg_data_i;
      end
    end
  end

  // The estimates are state and reset to their defined values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_q.rto    <= rte_pkg::TickW'(rte_pkg::InitialRtoReset);
      est_q.srtt   <= '0;
      est_q.rttvar <= '0;
    end else if (advance) begin
      est_q <= est_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_est_q   <= est_d;
      out_flags_q <= flags;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_flags_q.backoff_clear, out_flags_q.sample_used,
                          out_est_q.rttvar, out_est_q.srtt, out_est_q.rto};

endmodule
